// ===== rtl/totp_pkg.sv =====
// ----------------------------------------------------------------------------
// totp_pkg
// Shared types, codes and constants for the TOTP code generator.
// ----------------------------------------------------------------------------
package totp_pkg;

    localparam int KEY_BYTES = 64;
    localparam int KEY_AW    = $clog2(KEY_BYTES);

    typedef enum logic [1:0] {
        FN_CLEAR  = 2'd0,
        FN_APPEND = 2'd1,
        FN_GEN    = 2'd2,
        FN_VERIFY = 2'd3
    } func_t;

    localparam logic CFG_STEP   = 1'b0;
    localparam logic CFG_DIGITS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_KLOAD,
        ST_BLK2,
        ST_ROUND,
        ST_HADD,
        ST_TRUNC,
        ST_MOD,
        ST_CHECK,
        ST_RESULT
    } state_t;

    // counter end values (7-bit step counter)
    localparam logic [6:0] DIV_LAST   = 7'd63;
    localparam logic [6:0] MOD_LAST   = 7'd30;
    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [6:0] BLOCK_LEN  = 7'd64;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [7:0] IPAD = 8'h36;
    localparam logic [7:0] OPAD = 8'h5C;

    localparam logic [63:0] INNER_BITS = 64'd576;
    localparam logic [63:0] OUTER_BITS = 64'd672;

    typedef struct packed {
        logic in_stall;
        logic accept;
        logic out_load;
    } ctl_t;

    function automatic logic [29:0] pow10(input logic [3:0] digits);
        logic [29:0] r;
        case (digits)
            4'd0:    r = 30'd1;
            4'd1:    r = 30'd10;
            4'd2:    r = 30'd100;
            4'd3:    r = 30'd1000;
            4'd4:    r = 30'd10000;
            4'd5:    r = 30'd100000;
            4'd6:    r = 30'd1000000;
            4'd7:    r = 30'd10000000;
            4'd8:    r = 30'd100000000;
            default: r = 30'd1000000000;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/totp_code_generator_unit.sv =====
// ----------------------------------------------------------------------------
// totp_code_generator_unit
// HMAC-SHA1 time-based one-time password generator and checker.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries func, key_byte, timestamp, code.
//   One result item per input item on out_valid/out_stall.
//   Append past 64 bytes flags key_overflow.
//   Generate does a bit-serial divide of the timestamp by the step, four
//   SHA-1 blocks of 80 rounds (one round per cycle), a fetch of each of the
//   two key blocks from the one-port key RAM first, and a modulo.
//   Verify repeats the per-window work three times.
//   One item is worked on at a time; in_stall is high while busy.
//   The result sits in an output register; a new item is taken while it
//   waits, and a later result waits in the result state until the output
//   register frees up.
//   Configuration writes (cfg_we) must only come while the block is idle.
//   Reset clears the key length, the output valid and the config registers
//   (step 30 s, 6 digits). Key RAM contents are not cleared.
// ----------------------------------------------------------------------------
module totp_code_generator_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  key_byte,
    input  logic [63:0] timestamp,
    input  logic [29:0] code,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [29:0] otp_value,
    output logic        code_matches,
    output logic        key_overflow
);
    import totp_pkg::*;

    state_t state_reg, state_next;
    ctl_t   ctl;

    logic        out_valid_reg;
    logic [6:0]  key_length_reg;
    logic [31:0] step_reg;
    logic [3:0]  digits_reg;

    logic [7:0]  key_mem [KEY_BYTES];
    logic [7:0]  key_q_reg;
    logic        key_in_reg;

    logic [6:0]   cnt_reg;
    logic [63:0]  ts_reg;
    logic [29:0]  cand_reg;
    logic         verify_reg;
    logic [1:0]   win_reg;
    logic [63:0]  dq_reg;
    logic [31:0]  rem_reg;
    logic [63:0]  ctr_reg;
    logic [511:0] blk_reg;
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]  h0_reg, h1_reg, h2_reg, h3_reg, h4_reg;
    logic [159:0] ih_reg;
    logic         pass_reg;
    logic         second_reg;
    logic [29:0]  otp_pend_reg;
    logic         match_pend_reg;
    logic         ovf_pend_reg;
    logic [29:0]  otp_value_reg;
    logic         code_matches_reg;
    logic         key_overflow_reg;

    // derived values
    logic [31:0]  step_eff;
    logic [29:0]  modulus;
    logic [63:0]  ts_win;
    logic [31:0]  den;
    logic [32:0]  trial;
    logic [32:0]  trial_sub;
    logic         ge;
    logic [31:0]  rem_next;
    logic [63:0]  dq_next;
    logic [31:0]  f_val, k_val, t_val, w0, w_new;
    logic [31:0]  s0, s1, s2, s3, s4;
    logic [7:0]   key_in_byte;
    logic [159:0] mac, mac_sh;
    logic [511:0] blk2;
    logic         append_ok;

    assign step_eff = (step_reg == 32'd0) ? 32'd1 : step_reg;
    assign modulus  = pow10(digits_reg);
    assign append_ok = (key_length_reg < 7'(KEY_BYTES));

    always_comb
    begin
        case (win_reg)
            2'd0:    ts_win = ts_reg - {32'd0, step_eff};
            2'd2:    ts_win = ts_reg + {32'd0, step_eff};
            default: ts_win = ts_reg;
        endcase
    end

    // shared restoring divider: timestamp / step, then word % 10^digits
    assign den       = (state_reg == ST_MOD) ? {2'b00, modulus} : step_eff;
    assign trial     = {rem_reg, dq_reg[63]};
    assign trial_sub = trial - {1'b0, den};
    assign ge        = (trial >= {1'b0, den});
    assign rem_next  = ge ? trial_sub[31:0] : trial[31:0];
    assign dq_next   = {dq_reg[62:0], ge};

    // SHA-1 round
    assign w0    = blk_reg[511:480];
    assign w_new = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ w0;

    always_comb
    begin
        if (cnt_reg < 7'd20)
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = 32'h5A827999;
        end
        else if (cnt_reg < 7'd40)
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'h6ED9EBA1;
        end
        else if (cnt_reg < 7'd60)
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = 32'h8F1BBCDC;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = 32'hCA62C1D6;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w0;

    assign s0 = h0_reg + a_reg;
    assign s1 = h1_reg + b_reg;
    assign s2 = h2_reg + c_reg;
    assign s3 = h3_reg + d_reg;
    assign s4 = h4_reg + e_reg;

    assign key_in_byte = (key_in_reg ? key_q_reg : 8'h00) ^ (pass_reg ? OPAD : IPAD);

    assign blk2 = pass_reg ? {ih_reg, 32'h80000000, 256'd0, OUTER_BITS}
                           : {ctr_reg, 32'h80000000, 352'd0, INNER_BITS};

    // dynamic truncation
    assign mac    = {h0_reg, h1_reg, h2_reg, h3_reg, h4_reg};
    assign mac_sh = mac << {h4_reg[3:0], 3'b000};

    // control strobes
    always_comb
    begin
        ctl.in_stall = (state_reg != ST_IDLE);
        ctl.accept   = in_valid && (state_reg == ST_IDLE);
        ctl.out_load = (state_reg == ST_RESULT) && (!out_valid_reg || !out_stall);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.accept)
                begin
                    if (func == FN_GEN || func == FN_VERIFY)
                        state_next = ST_SETUP;
                    else
                        state_next = ST_RESULT;
                end
            end
            ST_SETUP:
                state_next = ST_DIV;
            ST_DIV:
            begin
                if (cnt_reg == DIV_LAST)
                    state_next = ST_KLOAD;
            end
            ST_KLOAD:
            begin
                if (cnt_reg == BLOCK_LEN)
                    state_next = ST_ROUND;
            end
            ST_BLK2:
                state_next = ST_ROUND;
            ST_ROUND:
            begin
                if (cnt_reg == ROUND_LAST)
                    state_next = ST_HADD;
            end
            ST_HADD:
            begin
                if (!second_reg)
                    state_next = ST_BLK2;
                else if (!pass_reg)
                    state_next = ST_KLOAD;
                else
                    state_next = ST_TRUNC;
            end
            ST_TRUNC:
                state_next = ST_MOD;
            ST_MOD:
            begin
                if (cnt_reg == MOD_LAST)
                    state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (verify_reg && win_reg != 2'd2)
                    state_next = ST_SETUP;
                else
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (ctl.out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            out_valid_reg  <= 1'b0;
            key_length_reg <= 7'd0;
            step_reg       <= 32'd30;
            digits_reg     <= 4'd6;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STEP:   step_reg   <= cfg_data;
                    CFG_DIGITS: digits_reg <= cfg_data[3:0];
                    default:    step_reg   <= step_reg;
                endcase
            end
            if (ctl.accept && func == FN_CLEAR)
                key_length_reg <= 7'd0;
            else if (ctl.accept && func == FN_APPEND && append_ok)
                key_length_reg <= key_length_reg + 7'd1;
        end
    end

    // key RAM, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.accept && func == FN_APPEND && append_ok)
            key_mem[key_length_reg[KEY_AW-1:0]] <= key_byte;
        key_q_reg  <= key_mem[cnt_reg[KEY_AW-1:0]];
        key_in_reg <= (cnt_reg < key_length_reg);
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (ctl.accept)
                begin
                    ts_reg         <= timestamp;
                    cand_reg       <= code;
                    verify_reg     <= (func == FN_VERIFY);
                    win_reg        <= (func == FN_VERIFY) ? 2'd0 : 2'd1;
                    otp_pend_reg   <= 30'd0;
                    match_pend_reg <= 1'b0;
                    ovf_pend_reg   <= (func == FN_APPEND) && !append_ok;
                end
            end
            ST_SETUP:
            begin
                dq_reg  <= ts_win;
                rem_reg <= 32'd0;
                cnt_reg <= 7'd0;
            end
            ST_DIV:
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    ctr_reg    <= dq_next;
                    cnt_reg    <= 7'd0;
                    pass_reg   <= 1'b0;
                    second_reg <= 1'b0;
                    h0_reg <= H0_INIT;
                    h1_reg <= H1_INIT;
                    h2_reg <= H2_INIT;
                    h3_reg <= H3_INIT;
                    h4_reg <= H4_INIT;
                end
            end
            ST_KLOAD:
            begin
                // byte read at one count is shifted in at the next count
                if (cnt_reg != 7'd0)
                    blk_reg <= {blk_reg[503:0], key_in_byte};
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == BLOCK_LEN)
                begin
                    cnt_reg <= 7'd0;
                    a_reg <= h0_reg;
                    b_reg <= h1_reg;
                    c_reg <= h2_reg;
                    d_reg <= h3_reg;
                    e_reg <= h4_reg;
                end
            end
            ST_BLK2:
            begin
                blk_reg    <= blk2;
                second_reg <= 1'b1;
                cnt_reg    <= 7'd0;
                a_reg <= h0_reg;
                b_reg <= h1_reg;
                c_reg <= h2_reg;
                d_reg <= h3_reg;
                e_reg <= h4_reg;
            end
            ST_ROUND:
            begin
                a_reg   <= t_val;
                b_reg   <= a_reg;
                c_reg   <= {b_reg[1:0], b_reg[31:2]};
                d_reg   <= c_reg;
                e_reg   <= d_reg;
                blk_reg <= {blk_reg[479:0], w_new[30:0], w_new[31]};
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_HADD:
            begin
                cnt_reg <= 7'd0;
                if (second_reg && !pass_reg)
                begin
                    ih_reg     <= {s0, s1, s2, s3, s4};
                    pass_reg   <= 1'b1;
                    second_reg <= 1'b0;
                    h0_reg <= H0_INIT;
                    h1_reg <= H1_INIT;
                    h2_reg <= H2_INIT;
                    h3_reg <= H3_INIT;
                    h4_reg <= H4_INIT;
                end
                else
                begin
                    h0_reg <= s0;
                    h1_reg <= s1;
                    h2_reg <= s2;
                    h3_reg <= s3;
                    h4_reg <= s4;
                end
            end
            ST_TRUNC:
            begin
                dq_reg  <= {mac_sh[158:128], 33'd0};
                rem_reg <= 32'd0;
                cnt_reg <= 7'd0;
            end
            ST_MOD:
            begin
                dq_reg  <= dq_next;
                rem_reg <= rem_next;
                cnt_reg <= cnt_reg + 7'd1;
            end
            ST_CHECK:
            begin
                if (verify_reg)
                begin
                    if (rem_reg[29:0] == cand_reg)
                        match_pend_reg <= 1'b1;
                    win_reg <= win_reg + 2'd1;
                end
                else
                    otp_pend_reg <= rem_reg[29:0];
            end
            ST_RESULT:
            begin
                if (ctl.out_load)
                begin
                    otp_value_reg    <= otp_pend_reg;
                    code_matches_reg <= match_pend_reg;
                    key_overflow_reg <= ovf_pend_reg;
                end
            end
            default:
                cnt_reg <= 7'd0;
        endcase
    end

    assign in_stall     = ctl.in_stall;
    assign out_valid    = out_valid_reg;
    assign otp_value    = otp_value_reg;
    assign code_matches = code_matches_reg;
    assign key_overflow = key_overflow_reg;

endmodule
